>>> hw/rtl/cmfcrc_pkg.sv
`timescale 1ns / 1ps

package cmfcrc_pkg;

   // Widest CRC register the block is built for by default
   localparam int unsigned DEFAULT_MAX_WIDTH = 32;

   // Reset values of the configuration registers (CRC-32/MPEG-2 preset: CRC-32 polynomial, all-ones init)
   localparam logic [31:0] DEFAULT_POLYNOMIAL = 32'h04C1_1DB7;
   localparam logic [5:0]  DEFAULT_CRC_WIDTH  = 6'd32;
   localparam logic [31:0] DEFAULT_INIT_VALUE = 32'hFFFF_FFFF;

   // Narrowest CRC the block supports
   localparam logic [6:0]  MIN_CRC_WIDTH = 7'd8;

   // Configuration register indexes
   localparam logic [1:0] CSR_POLYNOMIAL = 2'd0;
   localparam logic [1:0] CSR_CRC_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_INIT_VALUE = 2'd2;

   // Start value selection carried with each request
   typedef enum logic [1:0] {
      MODE_CONTINUE = 2'd0,
      MODE_INIT     = 2'd1,
      MODE_SEED     = 2'd2
   } mode_type;

endpackage

>>> hw/rtl/cmfcrc_csr.sv
`timescale 1ns / 1ps

module cmfcrc_csr import cmfcrc_pkg::*; #(
   parameter int unsigned MAX_WIDTH = DEFAULT_MAX_WIDTH,
   localparam int unsigned SHIFT_W = $clog2(MAX_WIDTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output logic [MAX_WIDTH-1:0] poly,
   output logic [MAX_WIDTH-1:0] init,
   output logic [SHIFT_W-1:0]   shift
);

   localparam logic [6:0] MAX_W7 = 7'(MAX_WIDTH);

   logic [31:0] poly_ff, poly_in;
   logic [5:0]  width_ff, width_in;
   logic [31:0] init_ff, init_in;
   logic [6:0]  eff_width;

   assign csr_ready = 1'b1;

   always_comb begin
      poly_in  = poly_ff;
      width_in = width_ff;
      init_in  = init_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_POLYNOMIAL: poly_in  = csr_wdata;
            CSR_CRC_WIDTH:  width_in = csr_wdata[5:0];
            CSR_INIT_VALUE: init_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff  <= DEFAULT_POLYNOMIAL;
         width_ff <= DEFAULT_CRC_WIDTH;
         init_ff  <= DEFAULT_INIT_VALUE;
      end else begin
         poly_ff  <= poly_in;
         width_ff <= width_in;
         init_ff  <= init_in;
      end
   end

   // Clamp the width into the supported range
   always_comb begin
      if ({1'b0, width_ff} < MIN_CRC_WIDTH) begin
         eff_width = MIN_CRC_WIDTH;
      end else if ({1'b0, width_ff} > MAX_W7) begin
         eff_width = MAX_W7;
      end else begin
         eff_width = {1'b0, width_ff};
      end
   end

   // Left shift that puts the CRC's top bit at the register's top bit
   assign shift = SHIFT_W'(MAX_W7 - eff_width);
   assign poly  = MAX_WIDTH'(poly_ff);
   assign init  = MAX_WIDTH'(init_ff);

endmodule

>>> hw/rtl/cmfcrc_fold.sv
`timescale 1ns / 1ps

module cmfcrc_fold import cmfcrc_pkg::*; #(
   parameter int unsigned MAX_WIDTH = DEFAULT_MAX_WIDTH,
   localparam int unsigned SHIFT_W = $clog2(MAX_WIDTH)
) (
   input  logic [1:0]           mode,
   input  logic [7:0]           data_byte,
   input  logic [31:0]          seed_value,
   input  logic [MAX_WIDTH-1:0] running,
   input  logic [MAX_WIDTH-1:0] init,
   input  logic [MAX_WIDTH-1:0] poly,
   input  logic [SHIFT_W-1:0]   shift,
   output logic [MAX_WIDTH-1:0] crc_next
);

   logic [MAX_WIDTH-1:0] mask;
   logic [MAX_WIDTH-1:0] start;
   logic [MAX_WIDTH-1:0] poly_al;
   logic [MAX_WIDTH-1:0] crc_al;

   assign mask = {MAX_WIDTH{1'b1}} >> shift;

   always_comb begin
      case (mode_type'(mode))
         MODE_INIT: start = init;
         MODE_SEED: start = MAX_WIDTH'(seed_value);
         default:   start = running;
      endcase
   end

   assign poly_al = (poly & mask) << shift;

   // Work left-aligned so the feedback tap is always the top bit
   always_comb begin
      crc_al = ((start & mask) << shift) ^ (MAX_WIDTH'(data_byte) << (MAX_WIDTH - 8));
      for (int k = 0; k < 8; k++) begin
         crc_al = {crc_al[MAX_WIDTH-2:0], 1'b0} ^ (crc_al[MAX_WIDTH-1] ? poly_al : '0);
      end
   end

   assign crc_next = crc_al >> shift;

endmodule

>>> hw/rtl/configurable_msb_first_crc.sv
`timescale 1ns / 1ps

// Byte-serial, MSB-first, non-reflected CRC of 8 to MAX_WIDTH bits.
//
// Request channel (req_valid / req_stall): one data byte per request, with a
// mode that continues the running CRC, restarts from the init register or
// restarts from req_seed_value, plus a last-byte flag that is passed along.
// Response channel (rsp_valid / rsp_stall): one response per request holding
// the CRC after that byte, masked to the configured width, and the flag.
// CSR channel (csr_valid / csr_ready): index 0 polynomial, 1 width, 2 init
// value; csr_ready is always high. Write only while no request is in flight.
//
// A request sits in the input register, the eight-step update runs there and
// the result lands in the output register, which drives the response. One
// request is taken every cycle unless req_stall is high; the running CRC
// register closes its loop through the update. When the receiver stalls, the
// response holds and the input register keeps the next request; req_stall
// rises only when both are occupied.
// Reset empties both registers, loads the CRC-32 preset into the CSRs and
// sets the running CRC to the preset init value.

module configurable_msb_first_crc import cmfcrc_pkg::*; #(
   parameter int unsigned MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_seed_value,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_crc_value,
   output logic        rsp_is_final
);

   localparam int unsigned SHIFT_W = $clog2(MAX_WIDTH);

   logic [MAX_WIDTH-1:0] poly;
   logic [MAX_WIDTH-1:0] init;
   logic [SHIFT_W-1:0]   shift;
   logic [MAX_WIDTH-1:0] crc_next;

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic [1:0]           in_mode_ff;
   logic [31:0]          in_seed_ff;
   logic                 in_last_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [31:0]          out_crc_ff;
   logic                 out_last_ff;
   logic [MAX_WIDTH-1:0] running_ff;

   logic advance;
   logic move;
   logic take;

   cmfcrc_csr #(.MAX_WIDTH(MAX_WIDTH)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .poly      (poly),
      .init      (init),
      .shift     (shift)
   );

   cmfcrc_fold #(.MAX_WIDTH(MAX_WIDTH)) u_fold (
      .mode       (in_mode_ff),
      .data_byte  (in_byte_ff),
      .seed_value (in_seed_ff),
      .running    (running_ff),
      .init       (init),
      .poly       (poly),
      .shift      (shift),
      .crc_next   (crc_next)
   );

   assign advance   = !out_valid_ff || !rsp_stall;
   assign move      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (advance) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         running_ff   <= MAX_WIDTH'(DEFAULT_INIT_VALUE);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (move) begin
            running_ff <= crc_next;
         end
      end
   end

   // Payload: load on acceptance, hold otherwise
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_data_byte;
         in_mode_ff <= req_mode;
         in_seed_ff <= req_seed_value;
         in_last_ff <= req_last_byte;
      end
      if (move) begin
         out_crc_ff  <= 32'(crc_next);
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_crc_value = out_crc_ff;
   assign rsp_is_final  = out_last_ff;

endmodule

>>> hw/rtl/cmfcrc_checker.sv
`timescale 1ns / 1ps

module cmfcrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_crc_value,
   input logic        rsp_is_final
);

   // A stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_crc_value) && $stable(rsp_is_final))
      else $error("stalled response changed");

   // Reset leaves no response pending
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // An accepted request must show up as a response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("accepted request produced no response");

   // Requests are never held back while the response side is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

endmodule

bind configurable_msb_first_crc cmfcrc_checker u_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import cmfcrc_pkg::*;

   // Mode code the block treats as continue
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // Register index beyond the three real ones
   localparam logic [1:0] CSR_UNUSED  = 2'd3;

   typedef struct packed {
      logic [31:0] crc_value;
      logic        is_final;
   } crc_result_type;

   // Running CRC predictor plus the queue of CRCs still owed by the block
   class crc_scoreboard_type;
      logic [31:0] polynomial_reg;
      logic [5:0]  width_reg;
      logic [31:0] init_reg;
      logic [31:0] running_crc;
      crc_result_type expected_crcs[$];
      int          errors;

      function new();
         polynomial_reg = DEFAULT_POLYNOMIAL;
         width_reg      = DEFAULT_CRC_WIDTH;
         init_reg       = DEFAULT_INIT_VALUE;
         running_crc    = DEFAULT_INIT_VALUE;
         errors         = 0;
      endfunction

      function void write_register(logic [1:0] index, logic [31:0] value);
         case (index)
            CSR_POLYNOMIAL: polynomial_reg = value;
            CSR_CRC_WIDTH:  width_reg = value[5:0];
            CSR_INIT_VALUE: init_reg = value;
            default: ;
         endcase
      endfunction

      function int active_width();
         int w;
         w = int'(width_reg);
         if (w < int'(MIN_CRC_WIDTH)) w = int'(MIN_CRC_WIDTH);
         if (w > int'(DEFAULT_MAX_WIDTH)) w = int'(DEFAULT_MAX_WIDTH);
         return w;
      endfunction

      function logic [31:0] crc_after_byte(logic [31:0] start, logic [7:0] data_byte, int w);
         logic [63:0] mask;
         logic [63:0] top;
         logic [63:0] poly;
         logic [63:0] crc;
         mask = (64'd1 << w) - 64'd1;
         top  = 64'd1 << (w - 1);
         poly = {32'd0, polynomial_reg} & mask;
         crc  = ({32'd0, start} ^ ({56'd0, data_byte} << (w - 8))) & mask;
         for (int k = 0; k < 8; k++) begin
            if ((crc & top) != 64'd0) crc = ((crc << 1) ^ poly) & mask;
            else crc = (crc << 1) & mask;
         end
         return crc[31:0];
      endfunction

      function void note_request(logic [7:0] data_byte, logic [1:0] mode, logic [31:0] seed,
                                 logic last_byte);
         logic [31:0] start;
         crc_result_type res;
         if (mode == MODE_INIT) start = init_reg;
         else if (mode == MODE_SEED) start = seed;
         else start = running_crc;
         running_crc = crc_after_byte(start, data_byte, active_width());
         res.crc_value = running_crc;
         res.is_final  = last_byte;
         expected_crcs.push_back(res);
      endfunction

      function void report(string what, logic [31:0] exp_val, logic [31:0] act_val);
         errors++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_val, act_val);
      endfunction

      function void check_response(logic [31:0] crc_value, logic is_final);
         crc_result_type exp_res;
         if (expected_crcs.size() == 0) begin
            report("unexpected response crc_value", 32'hx, crc_value);
            return;
         end
         exp_res = expected_crcs.pop_front();
         if (crc_value !== exp_res.crc_value)
            report("crc_value", exp_res.crc_value, crc_value);
         if (is_final !== exp_res.is_final)
            report("is_final", {31'd0, exp_res.is_final}, {31'd0, is_final});
      endfunction

      function int pending();
         return expected_crcs.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic [1:0]  req_mode = '0;
   logic [31:0] req_seed_value = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_crc_value;
   logic        rsp_is_final;

   crc_scoreboard_type crc_model = new();
   bit         no_idle = 1'b0;
   int         rsp_hold_cycles = 0;

   configurable_msb_first_crc u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_mode       (req_mode),
      .req_seed_value (req_seed_value),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_crc_value  (rsp_crc_value),
      .rsp_is_final   (rsp_is_final)
   );

   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [5:0] pick_width();
      case ($urandom_range(0, 9))
         0: return 6'd0;
         1: return 6'd7;
         2: return 6'd8;
         3: return 6'd32;
         4: return 6'd33;
         5: return 6'd63;
         6: return 6'd16;
         default: return 6'($urandom_range(0, 63));
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 11))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h04C1_1DB7;
         3: return 32'h1EDC_6F41;
         4: return 32'h0000_1021;
         5: return 32'h0000_0007;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] data_byte, input logic [1:0] mode,
                            input logic [31:0] seed, input logic last_byte);
      int gap;
      req_valid      <= 1'b1;
      req_data_byte  <= data_byte;
      req_mode       <= mode;
      req_seed_value <= seed;
      req_last_byte  <= last_byte;
      do @(posedge clock); while (req_stall);
      crc_model.note_request(data_byte, mode, seed, last_byte);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop the request and let every owed response drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (crc_model.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_registers(input bit [3:0] which, input logic [31:0] poly,
                                    input logic [5:0] width, input logic [31:0] init);
      logic [1:0]  idx;
      logic [31:0] value;
      for (int i = 0; i < 4; i++) begin
         if (which[i]) begin
            idx = 2'(i);
            case (idx)
               CSR_POLYNOMIAL: value = poly;
               CSR_CRC_WIDTH:  value = {$urandom_range(0, 1) ? 26'h3FF_FFFF : 26'd0, width};
               CSR_INIT_VALUE: value = init;
               default:        value = $urandom;
            endcase
            csr_valid <= 1'b1;
            csr_index <= idx;
            csr_wdata <= value;
            do @(posedge clock); while (!csr_ready);
            crc_model.write_register(idx, value);
         end
      end
      csr_valid <= 1'b0;
   endtask

   // Response side: check, then choose the next stall
   initial begin
      int stall_left;
      stall_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            crc_model.check_response(rsp_crc_value, rsp_is_final);
         if (rsp_hold_cycles > 0) begin
            stall_left = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int          sent;
      int          len;
      bit          paused;
      logic [1:0]  first_mode;
      logic [31:0] seed;
      string       check_text;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: CRC-32 preset, continue straight out of reset
      no_idle = 1'b1;
      send_byte(8'h00, MODE_CONTINUE, 32'h0, 1'b0);
      check_text = "123456789";
      for (int i = 0; i < 9; i++)
         send_byte(check_text[i], (i == 0) ? MODE_INIT : MODE_CONTINUE, 32'h0, i == 8);
      send_byte(8'h00, MODE_SEED, 32'h0000_0000, 1'b0);
      send_byte(8'hFF, MODE_SEED, 32'hFFFF_FFFF, 1'b0);
      send_byte(8'hFF, MODE_UNUSED, 32'h1234_5678, 1'b1);
      send_byte(8'hA5, MODE_SEED, 32'h5A5A_5A5A, 1'b1);
      wait_idle();

      // Width below range, all-ones polynomial, zero init, spare index
      program_registers(4'b1111, 32'hFFFF_FFFF, 6'd0, 32'h0000_0000);
      send_byte(8'hFF, MODE_INIT, 32'h0, 1'b0);
      send_byte(8'h80, MODE_SEED, 32'hFFFF_FF00, 1'b0);
      send_byte(8'h01, MODE_CONTINUE, 32'h0, 1'b1);
      wait_idle();

      // Width above range, zero polynomial
      program_registers(4'b0111, 32'h0000_0000, 6'd63, 32'h1234_5678);
      send_byte(8'h7E, MODE_INIT, 32'h0, 1'b0);
      send_byte(8'h00, MODE_CONTINUE, 32'h0, 1'b1);
      wait_idle();

      // New init mid-message must leave the running CRC alone
      program_registers(4'b0111, 32'h0000_1021, 6'd16, 32'h0000_FFFF);
      send_byte(8'h31, MODE_INIT, 32'h0, 1'b0);
      wait_idle();
      program_registers(4'b0100, 32'h0, 6'd0, 32'hDEAD_BEEF);
      send_byte(8'h32, MODE_CONTINUE, 32'h0, 1'b0);
      wait_idle();
      // Narrow the width mid-message
      program_registers(4'b0010, 32'h0, 6'd8, 32'h0);
      send_byte(8'h33, MODE_CONTINUE, 32'h0, 1'b1);
      send_byte(8'hC3, MODE_INIT, 32'h0, 1'b1);
      wait_idle();

      // Random phases, each under its own register setting
      paused = 1'b0;
      for (int phase = 0; phase < 12; phase++) begin
         wait_idle();
         program_registers((phase % 3 == 0) ? 4'b1111 : 4'($urandom_range(1, 15)),
                           pick_word(), pick_width(), pick_word());
         no_idle = (phase % 4 == 1);
         if (phase == 3) begin
            // Receiver holds off while the sender keeps pushing
            no_idle = 1'b1;
            rsp_hold_cycles = 80;
         end
         sent = 0;
         while (sent < 75) begin
            if ($urandom_range(0, 9) < 8) begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
               case ($urandom_range(0, 9))
                  0:       first_mode = MODE_CONTINUE;
                  1, 2, 3: first_mode = MODE_SEED;
                  default: first_mode = MODE_INIT;
               endcase
               seed = $urandom;
               for (int i = 0; i < len; i++) begin
                  send_byte(8'($urandom_range(0, 255)), (i == 0) ? first_mode : MODE_CONTINUE,
                            (i == 0) ? seed : $urandom, i == len - 1);
                  sent++;
               end
            end else begin
               send_byte(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), $urandom,
                         1'($urandom_range(0, 1)));
               sent++;
            end
            if (phase == 6 && sent >= 40 && !paused) begin
               // Sender stops until the block has answered everything
               wait_idle();
               paused = 1'b1;
            end
         end
      end

      no_idle = 1'b0;
      req_valid <= 1'b0;
      while (crc_model.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (crc_model.errors == 0 && crc_model.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
